[rtl/sbrf_pkg.sv]
package sbrf_pkg;

    localparam int BUF_BYTES = 256;
    localparam int SLOTS     = BUF_BYTES;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int LANES     = 8;
    localparam int DATA_W    = LANES * 8;
    localparam int ESZ_W     = 4;
    localparam int FILL_W    = 9;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef struct packed {
        logic                      clr;
        logic                      wr_en;
        logic [IDX_W-1:0]          wr_idx;
        logic [LANES-1:0]          wr_be;
        logic [LANES-1:0][7:0]     wr_data;
        logic                      rd_en;
        logic [IDX_W-1:0]          rd_idx;
    } t_store_req;

    function automatic logic esz_legal(input logic [ESZ_W-1:0] e);
        logic ok;
        ok = 1'b0;
        case (e)
            4'd1, 4'd2, 4'd4, 4'd6, 4'd8: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [CNT_W-1:0] cap_of(input logic [ESZ_W-1:0] e);
        logic [CNT_W-1:0] c;
        c = CNT_W'(BUF_BYTES);
        case (e)
            4'd1:    c = CNT_W'(BUF_BYTES);
            4'd2:    c = CNT_W'(BUF_BYTES / 2);
            4'd4:    c = CNT_W'(BUF_BYTES / 4);
            4'd6:    c = CNT_W'(BUF_BYTES / 6);
            4'd8:    c = CNT_W'(BUF_BYTES / 8);
            default: c = CNT_W'(BUF_BYTES);
        endcase
        return c;
    endfunction

endpackage

[rtl/sbrf_store.sv]
module sbrf_store import sbrf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_req        i_req,
    output logic              o_wr_row_vld,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [LANES-1:0][7:0] r_mem [SLOTS];
    logic [SLOTS-1:0]      r_vld;
    logic [DATA_W-1:0]     r_rd;

    assign o_wr_row_vld = r_vld[i_req.wr_idx];
    assign o_rd_data    = r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            for (int b = 0; b < LANES; b++) begin
                if (i_req.wr_be[b]) begin
                    r_mem[i_req.wr_idx][b] <= i_req.wr_data[b];
                end
            end
        end
    end

    // invalid rows read as zero
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd <= r_vld[i_req.rd_idx] ? r_mem[i_req.rd_idx] : '0;
        end
    end

endmodule

[rtl/slotted_byte_ring_fifo.sv]
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: write_data, byte_count; tuser: cmd
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: read_data, fill_count; tuser: status
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_data: element_bytes
//
// One result per transfer; a new transfer is taken every cycle unless m_axis stalls; each
// passes the input register, then decision, store access and the result register.
// Slots live one per row of a 256 x 64-bit store with byte enables; one row a cycle.
// Reset and a legal element size write empty the FIFO at once (per-row valid bits).
// A stalled m_axis holds the result register; the input register takes one more
// transfer, then s_axis_tready drops.
module slotted_byte_ring_fifo import sbrf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [63:0] write_data, [67:64] byte_count
    input  logic [0:0]             s_axis_tuser,  // [0] cmd
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [63:0] read_data, [72:64] fill_count
    output logic [0:0]             m_axis_tuser,  // [0] status
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [ESZ_W-1:0]       i_cfg_data
);

    logic                   r_in_vld;
    logic                   r_in_cmd;
    logic [DATA_W-1:0]      r_in_data;
    logic [ESZ_W-1:0]       r_in_cnt;

    logic                   r_out_vld;
    logic                   r_out_status;
    logic [CNT_W-1:0]       r_out_fill;
    logic [LANES-1:0]       r_out_be;

    logic [ESZ_W-1:0]       r_esz;
    logic [CNT_W-1:0]       r_cap;
    logic [IDX_W-1:0]       r_head;
    logic [IDX_W-1:0]       r_tail;
    logic [CNT_W-1:0]       r_used;

    logic [IDX_W-1:0]       n_head;
    logic [IDX_W-1:0]       n_tail;
    logic [CNT_W-1:0]       n_used;

    logic                   adv;
    logic                   go;
    logic                   push_ok;
    logic                   pop_ok;
    logic                   cfg_wr;
    logic [CNT_W-1:0]       cap_m1;
    logic [LANES-1:0]       esz_be;
    logic                   wr_row_vld;
    logic [DATA_W-1:0]      rd_row;
    logic [DATA_W-1:0]      rd_masked;
    t_store_req             store_req;

    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || adv;
    assign go            = r_in_vld && adv;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid && esz_legal(i_cfg_data);
    assign cap_m1        = r_cap - CNT_W'(1);

    assign push_ok = (r_in_cmd == CMD_PUSH) && (r_in_cnt <= r_esz) && (r_used < r_cap);
    assign pop_ok  = (r_in_cmd == CMD_POP) && (r_in_cnt == r_esz) && (r_used != '0);

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_used = r_used;
        if (push_ok) begin
            n_tail = (r_tail == cap_m1[IDX_W-1:0]) ? '0 : r_tail + 1'b1;
            n_used = r_used + 1'b1;
        end else if (pop_ok) begin
            n_head = (r_head == cap_m1[IDX_W-1:0]) ? '0 : r_head + 1'b1;
            n_used = r_used - 1'b1;
        end
    end

    always_comb begin
        for (int b = 0; b < LANES; b++) begin
            esz_be[b] = ESZ_W'(b) < r_esz;
        end
    end

    // fresh rows get zeros above the pushed bytes
    always_comb begin
        store_req        = '0;
        store_req.clr    = cfg_wr;
        store_req.wr_en  = go && push_ok;
        store_req.wr_idx = r_tail;
        store_req.rd_en  = go;
        store_req.rd_idx = r_head;
        for (int b = 0; b < LANES; b++) begin
            store_req.wr_be[b]   = (ESZ_W'(b) < r_in_cnt) || !wr_row_vld;
            store_req.wr_data[b] = (ESZ_W'(b) < r_in_cnt) ? r_in_data[b*8 +: 8] : 8'h00;
        end
    end

    sbrf_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (store_req),
        .o_wr_row_vld (wr_row_vld),
        .o_rd_data    (rd_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser[0];
            r_in_data <= s_axis_tdata[DATA_W-1:0];
            r_in_cnt  <= s_axis_tdata[DATA_W +: ESZ_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esz  <= ESZ_W'(1);
            r_cap  <= cap_of(ESZ_W'(1));
            r_head <= '0;
            r_tail <= '0;
            r_used <= '0;
        end else if (cfg_wr) begin
            r_esz  <= i_cfg_data;
            r_cap  <= cap_of(i_cfg_data);
            r_head <= '0;
            r_tail <= '0;
            r_used <= '0;
        end else if (go) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_status <= (push_ok || pop_ok) ? ST_OK : ST_REJECT;
            r_out_fill   <= n_used;
            r_out_be     <= pop_ok ? esz_be : '0;
        end
    end

    always_comb begin
        for (int b = 0; b < LANES; b++) begin
            rd_masked[b*8 +: 8] = r_out_be[b] ? rd_row[b*8 +: 8] : 8'h00;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tuser[0] = r_out_status;
    assign m_axis_tdata    = OUT_TDATA_W'({FILL_W'(r_out_fill), rd_masked});

`ifndef ASSERT_OFF
    a_used_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_cap)
        else $error("fill count above capacity");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_head) < r_cap) && (CNT_W'(r_tail) < r_cap))
        else $error("head or tail past capacity");

    a_empty_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) |-> (r_head == r_tail))
        else $error("empty FIFO with head and tail apart");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[0] == ST_REJECT)) |-> (m_axis_tdata[DATA_W-1:0] == '0))
        else $error("rejected access returns data");

    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_used == '0))
        else $error("element size write left FIFO occupied");
`endif

endmodule
